### hw/rtl/salcp_pkg.sv
`timescale 1ns / 1ps

package salcp_pkg;

    localparam int MAX_TEXT    = 1024;
    localparam int SYMBOL_BITS = 8;
    localparam int SLOTS       = MAX_TEXT + 1;
    localparam int ALPHA       = (1 << SYMBOL_BITS) + 1;
    localparam int BUCKETS     = (SLOTS > ALPHA) ? SLOTS : ALPHA;
    localparam int IDX_W       = $clog2(SLOTS + 1);
    localparam int TXT_AW      = $clog2(MAX_TEXT);
    localparam int SYMX_W      = SYMBOL_BITS + 1;
    localparam int LCP_W       = 10;
    localparam int STAT_W      = 2;

    localparam logic [STAT_W-1:0] ST_LOAD = 2'd0;
    localparam logic [STAT_W-1:0] ST_READ = 2'd1;
    localparam logic [STAT_W-1:0] ST_ERR  = 2'd2;

    typedef struct packed {
        logic              valid;
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  suffix_start;
        logic [LCP_W-1:0]  common_prefix;
    } res_t;

endpackage

### hw/rtl/salcp_ram.sv
`timescale 1ns / 1ps

module salcp_ram #(
    parameter int W  = 8,
    parameter int D  = 16,
    parameter int AW = 4
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [D];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/salcp_engine.sv
`timescale 1ns / 1ps

module salcp_engine
    import salcp_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic                   mode,
    input  logic [SYMBOL_BITS-1:0] symbol,
    input  logic                   last,
    input  logic [IDX_W-1:0]       rank,
    output logic                   busy,
    output res_t                   res
);

    typedef enum logic [5:0] {
        IDLE, RESP, RD_WAIT, CLR, PS0, PS1,
        I_CNT0, I_CNT1, I_CNT2, I_PL0, I_PL1, I_PL2, I_RK0, I_RK1, I_RK2,
        D_SH0, D_SH1, D_CNT0, D_CNT1, D_CNT2, D_CNT3,
        D_PL0, D_PL1, D_PL2, D_PL3, D_RK0, D_RK1, D_RK2, D_RK3, D_CP0, D_CP1,
        K_INIT, K_POS0, K_POS1, K_PRV, K_C1, K_C2, K_C3, K_WR
    } state_t;

    localparam int SUM_W = IDX_W + 1;

    state_t              state_reg;
    logic [IDX_W-1:0]    i_reg, len_reg, kk_reg, classes_reg, cnt_reg, acc_reg;
    logic [IDX_W-1:0]    h_reg, pos_reg, prev_reg, s_reg, r_reg, ra_reg;
    logic [IDX_W-1:0]    ra_prev_reg, rb_prev_reg;
    logic [SYMX_W-1:0]   sym_reg, sym_prev_reg;
    logic [SYMBOL_BITS-1:0] t1_reg;
    logic                built_reg, dbl_reg;
    res_t                res_reg;

    // Memory ports.
    logic                   tx_we;
    logic [TXT_AW-1:0]      tx_wa, tx_ra;
    logic [SYMBOL_BITS-1:0] tx_wd, tx_q;
    logic                   sa_we, rk_we, tp_we, rs_we, bk_we, lc_we;
    logic [IDX_W-1:0]       sa_wa, sa_wd, sa_ra, sa_q;
    logic [IDX_W-1:0]       rk_wa, rk_wd, rk_ra, rk_q;
    logic [IDX_W-1:0]       tp_wa, tp_wd, tp_ra, tp_q;
    logic [IDX_W-1:0]       rs_wa, rs_wd, rs_ra, rs_q;
    logic [IDX_W-1:0]       bk_wa, bk_wd, bk_ra, bk_q;
    logic [IDX_W-1:0]       lc_wa, lc_ra;
    logic [LCP_W-1:0]       lc_wd, lc_q;

    salcp_ram #(.W(SYMBOL_BITS), .D(MAX_TEXT), .AW(TXT_AW)) u_text (
        .aclk, .we(tx_we), .waddr(tx_wa), .wdata(tx_wd), .raddr(tx_ra), .rdata(tx_q));
    salcp_ram #(.W(IDX_W), .D(SLOTS), .AW(IDX_W)) u_sa (
        .aclk, .we(sa_we), .waddr(sa_wa), .wdata(sa_wd), .raddr(sa_ra), .rdata(sa_q));
    salcp_ram #(.W(IDX_W), .D(SLOTS), .AW(IDX_W)) u_rank (
        .aclk, .we(rk_we), .waddr(rk_wa), .wdata(rk_wd), .raddr(rk_ra), .rdata(rk_q));
    salcp_ram #(.W(IDX_W), .D(SLOTS), .AW(IDX_W)) u_tmp (
        .aclk, .we(tp_we), .waddr(tp_wa), .wdata(tp_wd), .raddr(tp_ra), .rdata(tp_q));
    salcp_ram #(.W(IDX_W), .D(SLOTS), .AW(IDX_W)) u_rscr (
        .aclk, .we(rs_we), .waddr(rs_wa), .wdata(rs_wd), .raddr(rs_ra), .rdata(rs_q));
    salcp_ram #(.W(IDX_W), .D(BUCKETS), .AW(IDX_W)) u_bkt (
        .aclk, .we(bk_we), .waddr(bk_wa), .wdata(bk_wd), .raddr(bk_ra), .rdata(bk_q));
    salcp_ram #(.W(LCP_W), .D(SLOTS), .AW(IDX_W)) u_lcp (
        .aclk, .we(lc_we), .waddr(lc_wa), .wdata(lc_wd), .raddr(lc_ra), .rdata(lc_q));

    logic [IDX_W-1:0]  n_len, eff_len, bk_dec, cls_init, cls_dbl, sh_val, kk2;
    logic [SUM_W-1:0]  ih_sum, ph_sum, sk_sum, kk_sum;
    logic [SYMX_W-1:0] sym_i, sym_s;
    logic              last_i, i_end;

    assign n_len   = len_reg + IDX_W'(1);
    assign eff_len = built_reg ? '0 : len_reg;
    assign bk_dec  = bk_q - IDX_W'(1);
    assign last_i  = (i_reg == n_len - IDX_W'(1));
    assign i_end   = (i_reg == n_len - IDX_W'(2));
    assign sym_i   = (i_reg >= len_reg) ? '0 : {1'b0, tx_q} + SYMX_W'(1);
    assign sym_s   = (s_reg >= len_reg) ? '0 : {1'b0, tx_q} + SYMX_W'(1);
    assign cls_init = (i_reg == '0) ? IDX_W'(1) :
                      ((sym_s != sym_prev_reg) ? classes_reg + IDX_W'(1) : classes_reg);
    assign cls_dbl  = (i_reg == '0) ? IDX_W'(1) :
                      ((ra_reg != ra_prev_reg || rk_q != rb_prev_reg) ?
                       classes_reg + IDX_W'(1) : classes_reg);
    assign sh_val  = (sa_q >= kk_reg) ? sa_q - kk_reg : sa_q + n_len - kk_reg;
    assign ih_sum  = {1'b0, i_reg} + {1'b0, h_reg};
    assign ph_sum  = {1'b0, prev_reg} + {1'b0, h_reg};
    assign sk_sum  = {1'b0, s_reg} + {1'b0, kk_reg};
    assign kk_sum  = {kk_reg, 1'b0};
    assign kk2     = (kk_sum >= {1'b0, n_len}) ? IDX_W'(kk_sum - {1'b0, n_len})
                                               : kk_sum[IDX_W-1:0];

    always_comb begin
        tx_we = 1'b0; tx_wa = '0; tx_wd = symbol; tx_ra = '0;
        sa_we = 1'b0; sa_wa = '0; sa_wd = '0; sa_ra = '0;
        rk_we = 1'b0; rk_wa = '0; rk_wd = '0; rk_ra = '0;
        tp_we = 1'b0; tp_wa = '0; tp_wd = '0; tp_ra = '0;
        rs_we = 1'b0; rs_wa = '0; rs_wd = '0; rs_ra = '0;
        bk_we = 1'b0; bk_wa = '0; bk_wd = '0; bk_ra = '0;
        lc_we = 1'b0; lc_wa = '0; lc_wd = '0; lc_ra = '0;
        case (state_reg)
            IDLE: begin
                tx_we = start && !mode && (eff_len < IDX_W'(MAX_TEXT));
                tx_wa = eff_len[TXT_AW-1:0];
                sa_ra = rank;
                lc_ra = rank;
            end
            CLR: begin
                bk_we = 1'b1; bk_wa = i_reg;
            end
            PS0: bk_ra = i_reg;
            PS1: begin
                bk_we = 1'b1; bk_wa = i_reg; bk_wd = acc_reg + bk_q;
            end
            I_CNT0, I_PL0: tx_ra = i_reg[TXT_AW-1:0];
            I_CNT1, I_PL1: bk_ra = IDX_W'(sym_i);
            I_CNT2: begin
                bk_we = 1'b1; bk_wa = IDX_W'(sym_reg); bk_wd = bk_q + IDX_W'(1);
            end
            I_PL2: begin
                bk_we = 1'b1; bk_wa = IDX_W'(sym_reg); bk_wd = bk_dec;
                sa_we = 1'b1; sa_wa = bk_dec; sa_wd = i_reg;
            end
            I_RK0, D_SH0, D_RK0: sa_ra = i_reg;
            I_RK1: tx_ra = sa_q[TXT_AW-1:0];
            I_RK2: begin
                rk_we = 1'b1; rk_wa = s_reg; rk_wd = cls_init - IDX_W'(1);
            end
            D_SH1: begin
                tp_we = 1'b1; tp_wa = i_reg; tp_wd = sh_val;
            end
            D_CNT0, D_PL0: tp_ra = i_reg;
            D_CNT1, D_PL1: rk_ra = tp_q;
            D_CNT2, D_PL2: bk_ra = rk_q;
            D_CNT3: begin
                bk_we = 1'b1; bk_wa = s_reg; bk_wd = bk_q + IDX_W'(1);
            end
            D_PL3: begin
                bk_we = 1'b1; bk_wa = r_reg; bk_wd = bk_dec;
                sa_we = 1'b1; sa_wa = bk_dec; sa_wd = s_reg;
            end
            D_RK1: rk_ra = sa_q;
            D_RK2: rk_ra = (sk_sum >= {1'b0, n_len}) ? IDX_W'(sk_sum - {1'b0, n_len})
                                                     : sk_sum[IDX_W-1:0];
            D_RK3: begin
                rs_we = 1'b1; rs_wa = s_reg; rs_wd = cls_dbl - IDX_W'(1);
            end
            D_CP0: rs_ra = i_reg;
            D_CP1: begin
                rk_we = 1'b1; rk_wa = i_reg; rk_wd = rs_q;
            end
            K_INIT: begin
                lc_we = 1'b1;
            end
            K_POS0: rk_ra = i_reg;
            K_POS1: sa_ra = rk_q - IDX_W'(1);
            K_C1: tx_ra = ih_sum[TXT_AW-1:0];
            K_C2: tx_ra = ph_sum[TXT_AW-1:0];
            K_WR: begin
                lc_we = 1'b1; lc_wa = pos_reg; lc_wd = h_reg[LCP_W-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            len_reg   <= '0;
            built_reg <= 1'b0;
            res_reg   <= '0;
        end else begin
            res_reg.valid <= 1'b0;
            case (state_reg)
                IDLE: begin
                    if (start) begin
                        res_reg.suffix_start  <= '0;
                        res_reg.common_prefix <= '0;
                        if (!mode) begin
                            built_reg <= 1'b0;
                            if (eff_len < IDX_W'(MAX_TEXT)) begin
                                len_reg        <= eff_len + IDX_W'(1);
                                res_reg.status <= ST_LOAD;
                            end else begin
                                len_reg        <= eff_len;
                                res_reg.status <= ST_ERR;
                            end
                            if (last) begin
                                dbl_reg   <= 1'b0;
                                i_reg     <= '0;
                                cnt_reg   <= IDX_W'(ALPHA);
                                state_reg <= CLR;
                            end else begin
                                state_reg <= RESP;
                            end
                        end else if (!built_reg || rank > len_reg) begin
                            res_reg.status <= ST_ERR;
                            state_reg      <= RESP;
                        end else begin
                            state_reg <= RD_WAIT;
                        end
                    end
                end
                RESP: begin
                    res_reg.valid <= 1'b1;
                    state_reg     <= IDLE;
                end
                RD_WAIT: begin
                    res_reg.valid         <= 1'b1;
                    res_reg.status        <= ST_READ;
                    res_reg.suffix_start  <= sa_q;
                    res_reg.common_prefix <= lc_q;
                    state_reg             <= IDLE;
                end
                CLR: begin
                    if (i_reg == cnt_reg - IDX_W'(1)) begin
                        i_reg     <= '0;
                        state_reg <= dbl_reg ? D_CNT0 : I_CNT0;
                    end else begin
                        i_reg <= i_reg + IDX_W'(1);
                    end
                end
                PS0: state_reg <= PS1;
                PS1: begin
                    acc_reg <= acc_reg + bk_q;
                    if (i_reg == cnt_reg - IDX_W'(1)) begin
                        i_reg     <= n_len - IDX_W'(1);
                        state_reg <= dbl_reg ? D_PL0 : I_PL0;
                    end else begin
                        i_reg     <= i_reg + IDX_W'(1);
                        state_reg <= PS0;
                    end
                end
                I_CNT0: state_reg <= I_CNT1;
                I_CNT1: begin
                    sym_reg   <= sym_i;
                    state_reg <= I_CNT2;
                end
                I_CNT2: begin
                    if (last_i) begin
                        i_reg     <= '0;
                        acc_reg   <= '0;
                        state_reg <= PS0;
                    end else begin
                        i_reg     <= i_reg + IDX_W'(1);
                        state_reg <= I_CNT0;
                    end
                end
                I_PL0: state_reg <= I_PL1;
                I_PL1: begin
                    sym_reg   <= sym_i;
                    state_reg <= I_PL2;
                end
                I_PL2: begin
                    if (i_reg == '0) begin
                        state_reg <= I_RK0;
                    end else begin
                        i_reg     <= i_reg - IDX_W'(1);
                        state_reg <= I_PL0;
                    end
                end
                I_RK0: state_reg <= I_RK1;
                I_RK1: begin
                    s_reg     <= sa_q;
                    state_reg <= I_RK2;
                end
                I_RK2: begin
                    classes_reg  <= cls_init;
                    sym_prev_reg <= sym_s;
                    if (last_i) begin
                        i_reg <= '0;
                        if (cls_init < n_len) begin
                            kk_reg    <= IDX_W'(1);
                            dbl_reg   <= 1'b1;
                            state_reg <= D_SH0;
                        end else begin
                            state_reg <= K_INIT;
                        end
                    end else begin
                        i_reg     <= i_reg + IDX_W'(1);
                        state_reg <= I_RK0;
                    end
                end
                D_SH0: state_reg <= D_SH1;
                D_SH1: begin
                    if (last_i) begin
                        i_reg     <= '0;
                        cnt_reg   <= classes_reg;
                        state_reg <= CLR;
                    end else begin
                        i_reg     <= i_reg + IDX_W'(1);
                        state_reg <= D_SH0;
                    end
                end
                D_CNT0: state_reg <= D_CNT1;
                D_CNT1: state_reg <= D_CNT2;
                D_CNT2: begin
                    s_reg     <= rk_q;
                    state_reg <= D_CNT3;
                end
                D_CNT3: begin
                    if (last_i) begin
                        i_reg     <= '0;
                        acc_reg   <= '0;
                        state_reg <= PS0;
                    end else begin
                        i_reg     <= i_reg + IDX_W'(1);
                        state_reg <= D_CNT0;
                    end
                end
                D_PL0: state_reg <= D_PL1;
                D_PL1: begin
                    s_reg     <= tp_q;
                    state_reg <= D_PL2;
                end
                D_PL2: begin
                    r_reg     <= rk_q;
                    state_reg <= D_PL3;
                end
                D_PL3: begin
                    if (i_reg == '0) begin
                        state_reg <= D_RK0;
                    end else begin
                        i_reg     <= i_reg - IDX_W'(1);
                        state_reg <= D_PL0;
                    end
                end
                D_RK0: state_reg <= D_RK1;
                D_RK1: begin
                    s_reg     <= sa_q;
                    state_reg <= D_RK2;
                end
                D_RK2: begin
                    ra_reg    <= rk_q;
                    state_reg <= D_RK3;
                end
                D_RK3: begin
                    classes_reg <= cls_dbl;
                    ra_prev_reg <= ra_reg;
                    rb_prev_reg <= rk_q;
                    if (last_i) begin
                        i_reg     <= '0;
                        state_reg <= D_CP0;
                    end else begin
                        i_reg     <= i_reg + IDX_W'(1);
                        state_reg <= D_RK0;
                    end
                end
                D_CP0: state_reg <= D_CP1;
                D_CP1: begin
                    if (last_i) begin
                        i_reg     <= '0;
                        kk_reg    <= kk2;
                        state_reg <= (classes_reg < n_len) ? D_SH0 : K_INIT;
                    end else begin
                        i_reg     <= i_reg + IDX_W'(1);
                        state_reg <= D_CP0;
                    end
                end
                K_INIT: begin
                    h_reg     <= '0;
                    i_reg     <= '0;
                    state_reg <= K_POS0;
                end
                K_POS0: state_reg <= K_POS1;
                K_POS1: begin
                    pos_reg <= rk_q;
                    if (rk_q == '0) begin
                        h_reg <= '0;
                        if (i_end) begin
                            built_reg <= 1'b1;
                            state_reg <= RESP;
                        end else begin
                            i_reg     <= i_reg + IDX_W'(1);
                            state_reg <= K_POS0;
                        end
                    end else begin
                        state_reg <= K_PRV;
                    end
                end
                K_PRV: begin
                    prev_reg  <= sa_q;
                    state_reg <= K_C1;
                end
                K_C1: begin
                    if (ih_sum >= {1'b0, len_reg} || ph_sum >= {1'b0, len_reg}) begin
                        state_reg <= K_WR;
                    end else begin
                        state_reg <= K_C2;
                    end
                end
                K_C2: begin
                    t1_reg    <= tx_q;
                    state_reg <= K_C3;
                end
                K_C3: begin
                    if (tx_q == t1_reg) begin
                        h_reg     <= h_reg + IDX_W'(1);
                        state_reg <= K_C1;
                    end else begin
                        state_reg <= K_WR;
                    end
                end
                K_WR: begin
                    h_reg <= (h_reg != '0) ? h_reg - IDX_W'(1) : '0;
                    if (i_end) begin
                        built_reg <= 1'b1;
                        state_reg <= RESP;
                    end else begin
                        i_reg     <= i_reg + IDX_W'(1);
                        state_reg <= K_POS0;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    assign busy = (state_reg != IDLE) || res_reg.valid;
    assign res  = res_reg;

endmodule

### hw/rtl/suffix_array_lcp_builder_core.sv
`timescale 1ns / 1ps

// Channel  Direction  Ports                                   Moves
// s_       in         s_mode s_symbol s_last s_rank           one load or read word
// m_       out        m_status m_suffix_start m_common_prefix one result word
//
// One word is taken at a time. A load or a read passes its result through the
// engine's result register into the output register, and the next word is taken
// only once the engine is idle and the result has left the output register or is
// being taken. A load marked last runs the whole build first: a sequencer walks
// the text, bucket, order and rank memories one entry at a time over the n =
// length + 1 slots in each doubling round, then runs the Kasai sweep. aresetn
// clears the length, the built flag, the state, the result register and the
// output valid flag; counters, output data and the memories are not cleared.
module suffix_array_lcp_builder_core
    import salcp_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_mode,
    input  logic [SYMBOL_BITS-1:0] s_symbol,
    input  logic                   s_last,
    input  logic [IDX_W-1:0]       s_rank,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [STAT_W-1:0]      m_status,
    output logic [IDX_W-1:0]       m_suffix_start,
    output logic [LCP_W-1:0]       m_common_prefix
);

    logic busy;
    res_t res;
    logic out_valid_reg;
    logic [STAT_W-1:0] out_status_reg;
    logic [IDX_W-1:0]  out_start_reg;
    logic [LCP_W-1:0]  out_lcp_reg;

    // A new word may enter only when the engine is idle and the output
    // register is free or drains in this cycle.
    assign s_ready = !busy && (!out_valid_reg || m_ready);

    salcp_engine u_engine (
        .aclk,
        .aresetn,
        .start  (s_valid && s_ready),
        .mode   (s_mode),
        .symbol (s_symbol),
        .last   (s_last),
        .rank   (s_rank),
        .busy,
        .res
    );

    // Output register holds each result word until the sink takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            if (res.valid) begin
                out_valid_reg  <= 1'b1;
                out_status_reg <= res.status;
                out_start_reg  <= res.suffix_start;
                out_lcp_reg    <= res.common_prefix;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_status        = out_status_reg;
    assign m_suffix_start  = out_start_reg;
    assign m_common_prefix = out_lcp_reg;

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the suffix array and LCP builder core.
// A directed table walks the corner cases first: reads before any build,
// single-byte and repeated-byte texts, the top rank and out-of-range ranks.
// After that, random texts are loaded, built and read back. One text runs
// past the capacity so that the overflow byte is dropped while the build still
// runs. Every accepted word is fed to a local model of the prefix-doubling
// sort and the Kasai sweep, and every result word is compared with the oldest
// prediction.
module testbench;
    import salcp_pkg::*;

    // Values of the mode field of an input word.
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_READ = 1'b1;

    // Generous cycle budget for the full-capacity build and the rest of the run.
    localparam int CYCLE_LIMIT = 4000000;
    localparam int LONG_HOLD   = 400;
    localparam int RAND_WORDS  = 600;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic                   s_mode = MODE_LOAD;
    logic [SYMBOL_BITS-1:0] s_symbol = '0;
    logic                   s_last = 1'b0;
    logic [IDX_W-1:0]       s_rank = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [STAT_W-1:0]      m_status;
    logic [IDX_W-1:0]       m_suffix_start;
    logic [LCP_W-1:0]       m_common_prefix;

    suffix_array_lcp_builder_core u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_symbol        (s_symbol),
        .s_last          (s_last),
        .s_rank          (s_rank),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_suffix_start  (m_suffix_start),
        .m_common_prefix (m_common_prefix)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // One result word as the block should produce it.
    typedef struct {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  start;
        logic [LCP_W-1:0]  lcp;
    } result_word_t;

    // One row of the directed table. When typed is set, the expected result is
    // the one written in the row; otherwise the local model supplies it.
    typedef struct {
        logic                   mode;
        logic [SYMBOL_BITS-1:0] symbol;
        logic                   last;
        logic [IDX_W-1:0]       rank;
        bit                     typed;
        logic [STAT_W-1:0]      status;
        logic [IDX_W-1:0]       start;
        logic [LCP_W-1:0]       lcp;
    } table_row_t;

    result_word_t pending_results[$];
    int fail_count = 0;
    int cycle_count = 0;
    int word_count = 0;

    // Knobs for the idling of both sides, in percent of cycles.
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;

    // The long receiver hold is timed by its own process. The stimulus asks for
    // one by bumping hold_req; the hold process answers by loading the counter.
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;

    // Local copy of the block's state.
    int text_bytes[MAX_TEXT];
    int text_len = 0;
    bit sa_built = 1'b0;
    int order_tab[SLOTS];
    int rank_tab[SLOTS];
    int shifted_order[SLOTS];
    int next_rank[SLOTS];
    int bucket_tab[BUCKETS];
    int lcp_tab[SLOTS];

    // Symbol at position p with the sentinel: the sentinel sorts as 0 and
    // every text byte as its value plus one.
    function automatic int text_sym(int p);
        if (p >= text_len) return 0;
        return text_bytes[p] + 1;
    endfunction

    // Prefix doubling on cyclic shifts with a counting sort per round, then
    // Kasai's sweep for the LCP of each rank with the rank below it.
    function automatic void build_suffix_array();
        int n, i, k, kk, classes, h, s, a, b, pos, prev;
        n = text_len + 1;
        for (i = 0; i < BUCKETS; i++) bucket_tab[i] = 0;
        for (i = 0; i < n; i++) bucket_tab[text_sym(i)]++;
        for (i = 1; i < ALPHA; i++) bucket_tab[i] += bucket_tab[i-1];
        for (i = n - 1; i >= 0; i--) begin
            bucket_tab[text_sym(i)]--;
            order_tab[bucket_tab[text_sym(i)]] = i;
        end
        rank_tab[order_tab[0]] = 0;
        classes = 1;
        for (i = 1; i < n; i++) begin
            if (text_sym(order_tab[i]) != text_sym(order_tab[i-1])) classes++;
            rank_tab[order_tab[i]] = classes - 1;
        end
        k = 1;
        while (classes < n) begin
            kk = k % n;
            for (i = 0; i < n; i++) shifted_order[i] = (order_tab[i] + n - kk) % n;
            for (i = 0; i < BUCKETS; i++) bucket_tab[i] = 0;
            for (i = 0; i < n; i++) bucket_tab[rank_tab[shifted_order[i]]]++;
            for (i = 1; i < classes; i++) bucket_tab[i] += bucket_tab[i-1];
            for (i = n - 1; i >= 0; i--) begin
                s = shifted_order[i];
                bucket_tab[rank_tab[s]]--;
                order_tab[bucket_tab[rank_tab[s]]] = s;
            end
            next_rank[order_tab[0]] = 0;
            classes = 1;
            for (i = 1; i < n; i++) begin
                a = order_tab[i];
                b = order_tab[i-1];
                if (rank_tab[a] != rank_tab[b] ||
                    rank_tab[(a + kk) % n] != rank_tab[(b + kk) % n])
                    classes++;
                next_rank[a] = classes - 1;
            end
            for (i = 0; i < n; i++) rank_tab[i] = next_rank[i];
            k = k * 2;
        end
        lcp_tab[0] = 0;
        h = 0;
        for (i = 0; i + 1 < n; i++) begin
            pos = rank_tab[i];
            if (pos == 0) begin
                h = 0;
            end else begin
                prev = order_tab[pos-1];
                while (i + h < n && prev + h < n && text_sym(i + h) == text_sym(prev + h)
                       && text_sym(i + h) != 0)
                    h++;
                lcp_tab[pos] = h;
                if (h > 0) h--;
            end
        end
        sa_built = 1'b1;
    endfunction

    // Advances the local state by one accepted word and returns its result.
    function automatic result_word_t predict_result(logic mode, logic [SYMBOL_BITS-1:0] symbol,
                                                    logic last, logic [IDX_W-1:0] rank);
        result_word_t r;
        r.status = ST_LOAD;
        r.start = '0;
        r.lcp = '0;
        if (mode == MODE_LOAD) begin
            if (sa_built) begin
                sa_built = 1'b0;
                text_len = 0;
            end
            if (text_len < MAX_TEXT) begin
                text_bytes[text_len] = int'(symbol);
                text_len++;
            end else begin
                r.status = ST_ERR;
            end
            if (last) begin
                if (text_len == 0) r.status = ST_ERR;
                else build_suffix_array();
            end
        end else if (!sa_built || int'(rank) > text_len) begin
            r.status = ST_ERR;
        end else begin
            r.status = ST_READ;
            r.start = IDX_W'(order_tab[rank]);
            r.lcp = LCP_W'(lcp_tab[rank]);
        end
        return r;
    endfunction

    // Offers one word, with idle cycles before it as the current knob asks,
    // and records the expected result once the word is taken.
    task automatic offer_word(logic mode, logic [SYMBOL_BITS-1:0] symbol, logic last,
                              logic [IDX_W-1:0] rank, bit typed, result_word_t typed_res);
        result_word_t r;
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        s_symbol <= symbol;
        s_last <= last;
        s_rank <= rank;
        do @(posedge aclk); while (!s_ready);
        r = predict_result(mode, symbol, last, rank);
        if (typed) r = typed_res;
        pending_results = {pending_results, r};
        word_count++;
    endtask

    task automatic offer_plain(logic mode, logic [SYMBOL_BITS-1:0] symbol, logic last,
                               logic [IDX_W-1:0] rank);
        result_word_t unused;
        unused.status = ST_LOAD;
        unused.start = '0;
        unused.lcp = '0;
        offer_word(mode, symbol, last, rank, 1'b0, unused);
    endtask

    // Stops offering and waits until every predicted result has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // A read rank: mostly valid ones, sometimes just past the end, sometimes
    // anything the field can hold.
    function automatic logic [IDX_W-1:0] pick_rank();
        if ($urandom_range(9) == 0) return IDX_W'($urandom_range(2047));
        return IDX_W'($urandom_range(text_len + 1));
    endfunction

    // A well-formed text: loads with the last flag on the final byte, then
    // reads. Small alphabets give many repeats and long common prefixes.
    task automatic send_text_and_reads();
        int len, alpha_sz, i;
        logic [SYMBOL_BITS-1:0] alphabet[4];
        len = ($urandom_range(9) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 16);
        alpha_sz = $urandom_range(1, 4);
        for (i = 0; i < 4; i++) alphabet[i] = SYMBOL_BITS'($urandom_range(255));
        for (i = 0; i < len; i++) begin
            if ($urandom_range(3) == 0)
                offer_plain(MODE_LOAD, SYMBOL_BITS'($urandom_range(255)), i == len - 1,
                            IDX_W'($urandom_range(2047)));
            else
                offer_plain(MODE_LOAD, alphabet[$urandom_range(alpha_sz - 1)], i == len - 1,
                            IDX_W'($urandom_range(2047)));
        end
        for (i = 0; i < len + 3; i++)
            offer_plain(MODE_READ, SYMBOL_BITS'($urandom_range(255)), 1'($urandom_range(1)),
                        pick_rank());
    endtask

    // Noise: loose loads without the last flag and reads against an unbuilt
    // or stale result.
    task automatic send_noise();
        int i, cnt;
        cnt = $urandom_range(1, 5);
        for (i = 0; i < cnt; i++) begin
            if ($urandom_range(1) == 0)
                offer_plain(MODE_LOAD, SYMBOL_BITS'($urandom_range(255)), 1'b0,
                            IDX_W'($urandom_range(2047)));
            else
                offer_plain(MODE_READ, SYMBOL_BITS'($urandom_range(255)), 1'($urandom_range(1)),
                            pick_rank());
        end
    endtask

    // Fills the text store to capacity and pushes one byte past it with the
    // last flag set: that byte is dropped with an error, and the build runs.
    task automatic send_overflow_text();
        int i, cnt;
        cnt = sa_built ? MAX_TEXT + 1 : MAX_TEXT - text_len + 1;
        for (i = 0; i < cnt; i++)
            offer_plain(MODE_LOAD, SYMBOL_BITS'($urandom_range(3) == 0 ? $urandom_range(255)
                                                                       : $urandom_range(1)),
                        i == cnt - 1, '0);
        offer_plain(MODE_READ, '0, 1'b0, IDX_W'(0));
        offer_plain(MODE_READ, '0, 1'b0, IDX_W'(MAX_TEXT));
        offer_plain(MODE_READ, '0, 1'b0, IDX_W'(MAX_TEXT + 1));
        for (i = 0; i < 12; i++) offer_plain(MODE_READ, '0, 1'b0, pick_rank());
    endtask

    // Long receiver hold, timed in its own process.
    always @(posedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_left <= LONG_HOLD;
            hold_ack <= hold_req;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Result side: check each taken word against the oldest prediction, then
    // pick the ready level for the next cycle.
    always @(posedge aclk) begin
        result_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result word: status=%0d start=%0d lcp=%0d",
                             m_status, m_suffix_start, m_common_prefix);
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status || m_suffix_start !== want.start ||
                    m_common_prefix !== want.lcp) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $write("result mismatch: expected status=%0d start=%0d lcp=%0d, ",
                               want.status, want.start, want.lcp);
                        $display("got status=%0d start=%0d lcp=%0d",
                                 m_status, m_suffix_start, m_common_prefix);
                    end
                end
            end
        end
        m_ready <= aresetn && (hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    table_row_t directed[18];

    initial begin
        int i, sent, phase, phase_words;
        result_word_t typed_res;

        directed = '{
            // Read with nothing built.
            '{MODE_READ, 8'h00, 1'b0, 11'd0,    1'b1, ST_ERR,  11'd0, 10'd0},
            // One-byte text of the top value: sentinel first, then the byte.
            '{MODE_LOAD, 8'hFF, 1'b1, 11'd0,    1'b1, ST_LOAD, 11'd0, 10'd0},
            '{MODE_READ, 8'h00, 1'b0, 11'd0,    1'b1, ST_READ, 11'd1, 10'd0},
            '{MODE_READ, 8'h00, 1'b0, 11'd1,    1'b1, ST_READ, 11'd0, 10'd0},
            // Ranks past the end, including the largest the field holds.
            '{MODE_READ, 8'h00, 1'b0, 11'd2,    1'b1, ST_ERR,  11'd0, 10'd0},
            '{MODE_READ, 8'hFF, 1'b1, 11'd2047, 1'b1, ST_ERR,  11'd0, 10'd0},
            // A load after a build drops the old result and starts anew.
            '{MODE_LOAD, 8'h00, 1'b0, 11'd2047, 1'b1, ST_LOAD, 11'd0, 10'd0},
            '{MODE_READ, 8'h00, 1'b0, 11'd0,    1'b1, ST_ERR,  11'd0, 10'd0},
            '{MODE_LOAD, 8'h00, 1'b0, 11'd0,    1'b1, ST_LOAD, 11'd0, 10'd0},
            '{MODE_LOAD, 8'h00, 1'b1, 11'd0,    1'b1, ST_LOAD, 11'd0, 10'd0},
            // Repeated zero bytes: from rank one on, the LCP grows by one per rank.
            '{MODE_READ, 8'h00, 1'b0, 11'd0,    1'b0, ST_LOAD, 11'd0, 10'd0},
            '{MODE_READ, 8'h00, 1'b0, 11'd1,    1'b0, ST_LOAD, 11'd0, 10'd0},
            '{MODE_READ, 8'h00, 1'b0, 11'd2,    1'b0, ST_LOAD, 11'd0, 10'd0},
            '{MODE_READ, 8'h00, 1'b0, 11'd3,    1'b0, ST_LOAD, 11'd0, 10'd0},
            // Alternating pattern with complementary bits.
            '{MODE_LOAD, 8'hAA, 1'b0, 11'd0,    1'b0, ST_LOAD, 11'd0, 10'd0},
            '{MODE_LOAD, 8'h55, 1'b0, 11'd0,    1'b0, ST_LOAD, 11'd0, 10'd0},
            '{MODE_LOAD, 8'hAA, 1'b1, 11'd0,    1'b0, ST_LOAD, 11'd0, 10'd0},
            '{MODE_READ, 8'h00, 1'b0, 11'd1,    1'b0, ST_LOAD, 11'd0, 10'd0}
        };

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < 18; i++) begin
            typed_res.status = directed[i].status;
            typed_res.start = directed[i].start;
            typed_res.lcp = directed[i].lcp;
            offer_word(directed[i].mode, directed[i].symbol, directed[i].last,
                       directed[i].rank, directed[i].typed, typed_res);
        end
        drain_results();

        // The overflow text runs with no idling so that it stays short.
        send_overflow_text();
        drain_results();

        // Random phases: no idling, idle sender, stalling receiver, both light.
        // The sender drains at each phase boundary. The long receiver hold
        // comes at the start of the stalling-receiver phase, while the
        // sender keeps offering words.
        for (phase = 0; phase < 4; phase++) begin
            tx_idle_pct = (phase == 1) ? 84 : (phase == 3) ? 7 : 0;
            rx_stall_pct = (phase == 2) ? 84 : (phase == 3) ? 7 : 0;
            if (phase == 2) hold_req <= hold_req + 1;
            phase_words = RAND_WORDS / 4;
            sent = word_count;
            while (word_count - sent < phase_words) begin
                if ($urandom_range(4) == 0) send_noise();
                else send_text_and_reads();
            end
            drain_results();
        end

        repeat (50) @(posedge aclk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/salcp_pkg.sv
hw/rtl/salcp_ram.sv
hw/rtl/salcp_engine.sv
hw/rtl/suffix_array_lcp_builder_core.sv
tb/testbench.sv
